[rtl/aoc_pkg.sv]
package aoc_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int NUM_STREAMS = 2;
    localparam int MAX_STREAMS = 4;
    localparam int POS_W       = 4;
    localparam logic [POS_W-1:0] POS_LAST = 4'd15;
    localparam int KEY_W       = 64;
    localparam int BLK_W       = 128;
    localparam int ROUNDS      = 10;
    localparam logic [3:0] ROUND_LAST = 4'd10;
    localparam int FIFO_DEPTH  = 2;

    typedef enum logic [0:0] {
        REG_KEY_LOW  = 1'b0,
        REG_KEY_HIGH = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic       we;
        reg_idx_t   index;
        logic [KEY_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] RCON [ROUNDS] = '{
        8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Next round key from the current one; byte 0 sits in the top bits
    function automatic logic [BLK_W-1:0] key_step(input logic [BLK_W-1:0] rk,
                                                  input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        n0 = w0 ^ t;
        n1 = w1 ^ n0;
        n2 = w2 ^ n1;
        n3 = w3 ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    // SubBytes, ShiftRows and, except in the final round, MixColumns
    function automatic logic [BLK_W-1:0] aes_round(input logic [BLK_W-1:0] s,
                                                   input logic fin);
        logic [7:0] sb [16];
        logic [7:0] ob [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [BLK_W-1:0] res;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                sb[r + 4*c] = SBOX[s[127 - 8*(r + 4*((c + r) % 4)) -: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0  = sb[4*c];
            a1  = sb[4*c + 1];
            a2  = sb[4*c + 2];
            a3  = sb[4*c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (fin) begin
                ob[4*c]     = a0;
                ob[4*c + 1] = a1;
                ob[4*c + 2] = a2;
                ob[4*c + 3] = a3;
            end
            else begin
                ob[4*c]     = a0 ^ all ^ xtime(a0 ^ a1);
                ob[4*c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
                ob[4*c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
                ob[4*c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            res[127 - 8*i -: 8] = ob[i];
        end
        return res;
    endfunction

endpackage

[rtl/aoc_front.sv]
module aoc_front #(
    parameter int NUM_STREAMS = aoc_pkg::NUM_STREAMS,
    parameter int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          data_byte,
    input  logic                stream_sel,
    input  logic                call_end,
    output logic                head_valid,
    output aoc_pkg::item_t      head_item,
    output logic [SW-1:0]       head_sid,
    input  logic                head_take
);

    aoc_pkg::item_t  item_reg [aoc_pkg::FIFO_DEPTH];
    logic [SW-1:0]   sid_reg  [aoc_pkg::FIFO_DEPTH];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      count_reg, count_next;
    logic            do_push, do_pop;
    logic [SW-1:0]   sid_in;

    // Out-of-range selects fall onto the last stream
    assign sid_in = (int'(stream_sel) >= NUM_STREAMS) ? SW'(NUM_STREAMS - 1) : SW'(stream_sel);

    assign full       = (count_reg == 2'(aoc_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = item_reg[rd_ptr_reg];
    assign head_sid   = sid_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_take && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            item_reg[wr_ptr_reg] <= '{data: data_byte, last: call_end};
            sid_reg[wr_ptr_reg]  <= sid_in;
        end
    end

endmodule

[rtl/aoc_back.sv]
module aoc_back #(
    parameter int NUM_STREAMS = aoc_pkg::NUM_STREAMS,
    parameter int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  aoc_pkg::cfg_wr_t    cfg,
    input  logic                head_valid,
    input  aoc_pkg::item_t      head_item,
    input  logic [SW-1:0]       head_sid,
    output logic                head_take,
    output logic                empty,
    input  logic                pop,
    output logic [7:0]          result_byte,
    output logic                result_last
);

    localparam int BW = aoc_pkg::BLK_W;

    logic [BW-1:0]             key_reg, key_next;
    logic [BW-1:0]             cur_reg [NUM_STREAMS];
    logic [BW-1:0]             nxt_reg [NUM_STREAMS];
    logic [NUM_STREAMS-1:0]    nxt_ok_reg, nxt_ok_next;
    logic [aoc_pkg::POS_W-1:0] pos_reg [NUM_STREAMS];
    logic [aoc_pkg::POS_W-1:0] pos_next [NUM_STREAMS];

    logic                      busy_reg;
    logic [3:0]                round_reg;
    logic [SW-1:0]             aes_sid_reg;
    logic [BW-1:0]             st_reg, rk_reg;
    logic [BW-1:0]             rk_step, st_step;

    logic                      out_valid_reg;
    logic [7:0]                out_byte_reg;
    logic                      out_last_reg;

    logic                      slot_free, issue, aes_start, aes_done, found;
    logic [SW-1:0]             start_sid;
    logic [aoc_pkg::POS_W-1:0] hpos;
    logic [7:0]                ks_byte;

    assign slot_free = !out_valid_reg || pop;
    assign hpos      = pos_reg[head_sid];
    assign issue     = head_valid && slot_free && !cfg.we
                       && ((hpos != '0) || nxt_ok_reg[head_sid]);
    assign head_take = issue;

    // Position zero draws from the precomputed block, which becomes current
    assign ks_byte = (hpos == '0)
                     ? nxt_reg[head_sid][BW-1 -: 8]
                     : cur_reg[head_sid][8*(aoc_pkg::BLOCK_BYTES - 1 - int'(hpos)) +: 8];

    always_comb
    begin
        found     = 1'b0;
        start_sid = '0;
        for (int s = 0; s < NUM_STREAMS; s++)
        begin
            if (!found && !nxt_ok_reg[s])
            begin
                found     = 1'b1;
                start_sid = SW'(s);
            end
        end
    end

    assign aes_start = !busy_reg && found && !cfg.we;
    assign rk_step   = aoc_pkg::key_step(rk_reg, aoc_pkg::RCON[round_reg - 4'd1]);
    assign st_step   = aoc_pkg::aes_round(st_reg, round_reg == aoc_pkg::ROUND_LAST) ^ rk_step;
    assign aes_done  = busy_reg && (round_reg == aoc_pkg::ROUND_LAST);

    always_comb
    begin
        key_next = key_reg;
        if (cfg.we)
        begin
            case (cfg.index)
                aoc_pkg::REG_KEY_LOW:  key_next = {key_reg[BW-1:aoc_pkg::KEY_W], cfg.data};
                aoc_pkg::REG_KEY_HIGH: key_next = {cfg.data, key_reg[aoc_pkg::KEY_W-1:0]};
                default:               key_next = key_reg;
            endcase
        end
    end

    always_comb
    begin
        nxt_ok_next = nxt_ok_reg;
        for (int s = 0; s < NUM_STREAMS; s++)
        begin
            pos_next[s] = pos_reg[s];
        end
        if (aes_done)
        begin
            nxt_ok_next[aes_sid_reg] = 1'b1;
        end
        if (issue)
        begin
            if (hpos == '0)
            begin
                nxt_ok_next[head_sid] = 1'b0;
            end
            if (head_item.last || (hpos == aoc_pkg::POS_LAST))
            begin
                pos_next[head_sid] = '0;
            end
            else
            begin
                pos_next[head_sid] = hpos + 1'b1;
            end
        end
        if (cfg.we)
        begin
            nxt_ok_next = '0;
            for (int s = 0; s < NUM_STREAMS; s++)
            begin
                pos_next[s] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= '0;
            nxt_ok_reg    <= '0;
            busy_reg      <= 1'b0;
            round_reg     <= 4'd0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < NUM_STREAMS; s++)
            begin
                pos_reg[s] <= '0;
                cur_reg[s] <= '0;
            end
        end
        else
        begin
            key_reg    <= key_next;
            nxt_ok_reg <= nxt_ok_next;
            for (int s = 0; s < NUM_STREAMS; s++)
            begin
                pos_reg[s] <= pos_next[s];
            end
            if (cfg.we)
            begin
                // rekey drops any block in flight and zeroes every stream
                busy_reg <= 1'b0;
                for (int s = 0; s < NUM_STREAMS; s++)
                begin
                    cur_reg[s] <= '0;
                end
            end
            else
            begin
                if (aes_start)
                begin
                    busy_reg  <= 1'b1;
                    round_reg <= 4'd1;
                end
                else if (busy_reg)
                begin
                    busy_reg  <= !aes_done;
                    round_reg <= round_reg + 4'd1;
                end
                if (issue && (hpos == '0))
                begin
                    cur_reg[head_sid] <= nxt_reg[head_sid];
                end
            end
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (aes_start)
        begin
            aes_sid_reg <= start_sid;
            st_reg      <= cur_reg[start_sid] ^ key_reg;
            rk_reg      <= key_reg;
        end
        else if (busy_reg)
        begin
            st_reg <= st_step;
            rk_reg <= rk_step;
        end
        if (aes_done && !cfg.we)
        begin
            nxt_reg[aes_sid_reg] <= st_step;
        end
        if (issue)
        begin
            out_byte_reg <= head_item.data ^ ks_byte;
            out_last_reg <= head_item.last;
        end
    end

    assign empty       = !out_valid_reg;
    assign result_byte = out_byte_reg;
    assign result_last = out_last_reg;

    a_busy_target: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !nxt_ok_reg[aes_sid_reg])
        else $error("round unit working on a stream whose next block is ready");

    a_issue_block: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> ((hpos != '0) || nxt_ok_reg[head_sid]))
        else $error("byte issued without keystream");

    a_rekey_stop: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.we |=> (!busy_reg && (nxt_ok_reg == '0)))
        else $error("key write left keystream state behind");

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ((round_reg >= 4'd1) && (round_reg <= aoc_pkg::ROUND_LAST)))
        else $error("round count out of range");

endmodule

[rtl/aes128_ofb_byte_stream_cipher.sv]
// AES-128 OFB byte cipher with independent keystreams sharing one key. Bytes are
// taken one per cycle while not full into a two-entry queue and leave one per cycle
// while popped, through an output register. Each stream holds its current
// keystream block and the next one, which a single iterative round unit computes
// ahead of use (load plus 10 rounds, one round and one key-schedule step per
// cycle). A byte that opens a new block waits only if that block is not yet
// ready, so short calls marked with call_end, or several streams opening blocks
// close together, can stall input. A key register write rekeys at once and
// zeroes every stream; write only while no byte is in flight.
module aes128_ofb_byte_stream_cipher #(
    parameter int NUM_STREAMS = aoc_pkg::NUM_STREAMS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [aoc_pkg::KEY_W-1:0]   cfg_data,
    input  logic                        push,
    output logic                        full,
    input  logic [7:0]                  data_byte,
    input  logic                        stream_sel,
    input  logic                        call_end,
    output logic                        empty,
    input  logic                        pop,
    output logic [7:0]                  result_byte,
    output logic                        result_last
);

    localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    aoc_pkg::cfg_wr_t cfg;
    logic             head_valid, head_take;
    aoc_pkg::item_t   head_item;
    logic [SW-1:0]    head_sid;

    assign cfg = '{we: cfg_we, index: aoc_pkg::reg_idx_t'(cfg_index), data: cfg_data};

    aoc_front #(.NUM_STREAMS(NUM_STREAMS), .SW(SW)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .data_byte  (data_byte),
        .stream_sel (stream_sel),
        .call_end   (call_end),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_sid   (head_sid),
        .head_take  (head_take)
    );

    aoc_back #(.NUM_STREAMS(NUM_STREAMS), .SW(SW)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .head_sid    (head_sid),
        .head_take   (head_take),
        .empty       (empty),
        .pop         (pop),
        .result_byte (result_byte),
        .result_last (result_last)
    );

endmodule

[tb/tb_aes128_ofb_byte_stream_cipher.sv]
`timescale 1ns / 100ps

module tb_aes128_ofb_byte_stream_cipher;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } cipher_out_t;

    // One row of the directed table; an expected value, when given, replaces the model's prediction
    typedef struct {
        logic [7:0] data;
        logic       sel;
        logic       last;
        logic       has_exp;
        logic [7:0] exp_byte;
    } dir_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic                      cfg_index = 1'b0;
    logic [aoc_pkg::KEY_W-1:0] cfg_data = '0;
    logic                      push = 1'b0;
    logic                      full;
    logic [7:0]                data_byte = '0;
    logic                      stream_sel = 1'b0;
    logic                      call_end = 1'b0;
    logic                      empty;
    logic                      pop = 1'b0;
    logic [7:0]                result_byte;
    logic                      result_last;

    logic [63:0]       key_lo_m, key_hi_m;
    logic [7:0]        rkey [176];
    logic [7:0]        fb_blk [2][16];
    logic [3:0]        fb_pos [2];
    cipher_out_t       out_queue [$];
    logic              check_byte_q [$];
    int                err_count = 0;
    int                byte_count = 0;
    int                rekey_count = 0;
    logic              drain_mode = 1'b0;
    logic              sink_quiet = 1'b0;

    aes128_ofb_byte_stream_cipher i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .push(push), .full(full), .data_byte(data_byte),
        .stream_sel(stream_sel), .call_end(call_end), .empty(empty), .pop(pop),
        .result_byte(result_byte), .result_last(result_last)
    );

    always #2 clk = ~clk;

    initial
    begin
        #20ms;
        $display("tb_aes128_ofb_byte_stream_cipher: errors");
        $finish;
    end

    function automatic logic [7:0] gmul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    task automatic expand_round_keys();
        logic [7:0] t [4];
        logic [7:0] x;
        for (int i = 0; i < 8; i++)
        begin
            rkey[i]     = key_hi_m[63 - 8*i -: 8];
            rkey[8 + i] = key_lo_m[63 - 8*i -: 8];
        end
        for (int i = 16; i < 176; i += 4)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = rkey[i - 4 + j];
            if (i % 16 == 0)
            begin
                x = t[0];
                t[0] = aoc_pkg::SBOX[t[1]] ^ aoc_pkg::RCON[i/16 - 1];
                t[1] = aoc_pkg::SBOX[t[2]];
                t[2] = aoc_pkg::SBOX[t[3]];
                t[3] = aoc_pkg::SBOX[x];
            end
            for (int j = 0; j < 4; j++)
                rkey[i + j] = rkey[i - 16 + j] ^ t[j];
        end
    endtask

    function automatic void encrypt_block(input int s);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] a0, a1, a2, a3, al;
        for (int i = 0; i < 16; i++)
            st[i] = fb_blk[s][i] ^ rkey[i];
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    tmp[r + 4*c] = aoc_pkg::SBOX[st[r + 4*((c + r) % 4)]];
            for (int c = 0; c < 4; c++)
            begin
                a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                if (rnd < 10)
                begin
                    st[4*c]   = a0 ^ al ^ gmul2(a0 ^ a1);
                    st[4*c+1] = a1 ^ al ^ gmul2(a1 ^ a2);
                    st[4*c+2] = a2 ^ al ^ gmul2(a2 ^ a3);
                    st[4*c+3] = a3 ^ al ^ gmul2(a3 ^ a0);
                end
                else
                begin
                    st[4*c] = a0; st[4*c+1] = a1; st[4*c+2] = a2; st[4*c+3] = a3;
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] ^= rkey[16*rnd + i];
        end
        for (int i = 0; i < 16; i++)
            fb_blk[s][i] = st[i];
    endfunction

    task automatic rekey_model(input aoc_pkg::reg_idx_t idx, input logic [63:0] val);
        if (idx == aoc_pkg::REG_KEY_LOW)
            key_lo_m = val;
        else
            key_hi_m = val;
        expand_round_keys();
        for (int s = 0; s < 2; s++)
        begin
            fb_pos[s] = '0;
            for (int i = 0; i < 16; i++)
                fb_blk[s][i] = '0;
        end
    endtask

    function automatic cipher_out_t keystream_xor(input logic [7:0] d, input logic s,
                                                  input logic l);
        cipher_out_t r;
        int p;
        p = fb_pos[s];
        if (p == 0)
            encrypt_block(s);
        r.data = d ^ fb_blk[s][p];
        r.last = l;
        fb_pos[s] = (l || p == 15) ? 4'd0 : 4'(p + 1);
        return r;
    endfunction

    // Push one byte; wait for the transfer; queue the prediction
    task automatic send_byte(input logic [7:0] d, input logic s, input logic l,
                             input logic chk);
        int gap;
        if (!drain_mode && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= d;
        stream_sel <= s;
        call_end <= l;
        @(posedge clk);
        while (full)
            @(posedge clk);
        out_queue.push_back(keystream_xor(d, s, l));
        check_byte_q.push_back(chk);
        byte_count++;
    endtask

    task automatic settle_idle();
        push <= 1'b0;
        @(posedge clk);
        while (out_queue.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_key(input aoc_pkg::reg_idx_t idx, input logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        rekey_model(idx, val);
        rekey_count++;
        @(posedge clk);
    endtask

    // Result side: random stalls, compare each transfer with the oldest prediction
    always @(posedge clk)
    begin
        cipher_out_t e;
        logic chk;
        if (rst_n && pop && !empty)
        begin
            if (out_queue.size() == 0)
            begin
                $error("unexpected result byte %h", result_byte);
                err_count++;
            end
            else
            begin
                e = out_queue.pop_front();
                chk = check_byte_q.pop_front();
                if (chk && result_byte !== e.data)
                begin
                    $error("result_byte expected %h actual %h", e.data, result_byte);
                    err_count++;
                end
                if (result_last !== e.last)
                begin
                    $error("result_last expected %b actual %b", e.last, result_last);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int stall;
        if (drain_mode)
            pop <= 1'b1;
        else if (sink_quiet)
            pop <= 1'b0;
        else if ($urandom_range(0, 9) == 0)
        begin
            pop <= 1'b0;
            stall = $urandom_range(1, 12);
            sink_quiet <= 1'b1;
            fork
                begin
                    repeat (stall) @(posedge clk);
                    sink_quiet <= 1'b0;
                end
            join_none
        end
        else
            pop <= 1'b1;
    end

    dir_row_t dir_tab [] = '{
        // zero key, zero block: the first keystream bytes of E(0) under zero key
        '{8'h00, 1'b0, 1'b0, 1'b1, 8'h66}, '{8'hff, 1'b0, 1'b0, 1'b1, 8'h16},
        '{8'h00, 1'b1, 1'b1, 1'b1, 8'h66}, '{8'hff, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'h5a, 1'b0, 1'b1, 1'b0, 8'h00}, '{8'ha5, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h01, 1'b1, 1'b0, 1'b0, 8'h00}, '{8'h80, 1'b1, 1'b1, 1'b0, 8'h00}
    };

    initial
    begin
        int n;
        logic s, l;
        rekey_model(aoc_pkg::REG_KEY_LOW, '0);
        rekey_model(aoc_pkg::REG_KEY_HIGH, '0);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            send_byte(dir_tab[i].data, dir_tab[i].sel, dir_tab[i].last, 1'b1);
            if (dir_tab[i].has_exp)
                out_queue[out_queue.size() - 1].data = dir_tab[i].exp_byte;
        end
        // full blocks with wrap on both streams
        for (int i = 0; i < 34; i++)
            send_byte(8'(i * 37), i[0], 1'b0, 1'b1);
        settle_idle();
        write_key(aoc_pkg::REG_KEY_LOW, 64'hffff_ffff_ffff_ffff);
        write_key(aoc_pkg::REG_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
        for (int i = 0; i < 20; i++)
            send_byte(8'($urandom), 1'b0, (i == 19), 1'b1);
        settle_idle();
        write_key(aoc_pkg::REG_KEY_HIGH, 64'h0);
        for (int i = 0; i < 5; i++)
            send_byte(8'($urandom), i[0], 1'b0, 1'b1);

        for (int ph = 0; ph < 6; ph++)
        begin
            settle_idle();
            write_key(aoc_pkg::reg_idx_t'(ph % 2), {$urandom, $urandom});
            if (ph == 5)
                drain_mode = 1'b1;
            n = 0;
            while (n < 125)
            begin
                s = 1'($urandom_range(0, 1));
                // calls of random length, mostly crossing block borders
                for (int k = $urandom_range(1, 40); k > 0 && n < 125; k--)
                begin
                    l = (k == 1) || ($urandom_range(0, 30) == 0);
                    send_byte(8'($urandom), s, l, 1'b1);
                    n++;
                    if ($urandom_range(0, 3) == 0)
                        s = ~s;
                end
            end
        end
        push <= 1'b0;
        n = 0;
        @(posedge clk);
        while (out_queue.size() != 0 && n < 10000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (20) @(posedge clk);
        if (out_queue.size() != 0)
        begin
            $error("%0d results never arrived", out_queue.size());
            err_count++;
        end
        $display("Covered %0d bytes on two streams across %0d key writes,", byte_count,
                 rekey_count);
        $display("with call ends, block wraps and random stalls on both sides.");
        if (err_count == 0)
            $display("tb_aes128_ofb_byte_stream_cipher: clean");
        else
            $display("tb_aes128_ofb_byte_stream_cipher: errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/aoc_pkg.sv
rtl/aoc_front.sv
rtl/aoc_back.sv
rtl/aes128_ofb_byte_stream_cipher.sv
tb/tb_aes128_ofb_byte_stream_cipher.sv
